@@ design/mt64_pkg.sv @@
// mt64_pkg: shared types, constants and helper functions for the 64-bit
// Mersenne Twister block. No dependencies.
`default_nettype none
package mt64_pkg;

  localparam int STATE_DEPTH   = 312;
  localparam int TWIST_OFFSET  = 156;
  localparam int KEY_MAX_WORDS = 64;

  localparam int IDX_W  = $clog2(STATE_DEPTH + 2);
  localparam int KEY_AW = (KEY_MAX_WORDS > 1) ? $clog2(KEY_MAX_WORDS) : 1;
  localparam int KEY_CW = $clog2(KEY_MAX_WORDS + 1);
  localparam int CNT_MAX = (KEY_MAX_WORDS > STATE_DEPTH) ? KEY_MAX_WORDS : STATE_DEPTH;
  localparam int CNT_W  = $clog2(CNT_MAX + 1);

  typedef logic [63:0] word_t;

  localparam word_t INIT_MULT    = 64'd6364136223846793005;
  localparam word_t MIX_MULT_A   = 64'd3935559000370003845;
  localparam word_t MIX_MULT_B   = 64'd2862933555777941757;
  localparam word_t ARRAY_SEED   = 64'd19650218;
  localparam word_t DEFAULT_SEED = 64'd5489;
  localparam word_t TWIST_MATRIX = 64'hB5026F5AA96619E9;
  localparam word_t TEMPER_D     = 64'h5555555555555555;
  localparam word_t TEMPER_B     = 64'h71D67FFFEDA60000;
  localparam word_t TEMPER_C     = 64'hFFF7EEE000000000;
  localparam word_t TOP_BIT      = 64'h8000000000000000;

  // item kinds
  localparam logic [1:0] KIND_DRAW   = 2'd0;
  localparam logic [1:0] KIND_RESEED = 2'd1;
  localparam logic [1:0] KIND_KEY    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LS_MUL,
    ST_TW_A,
    ST_TW_B,
    ST_TW_C,
    ST_TW_D,
    ST_DRAW_A,
    ST_DRAW_B,
    ST_A1_RD,
    ST_A1_CAP,
    ST_A1_MUL,
    ST_A2_RD,
    ST_A2_CAP,
    ST_A2_MUL,
    ST_FIN
  } state_t;

  function automatic word_t mix62(input word_t p);
    mix62 = p ^ (p >> 62);
  endfunction

  function automatic word_t temper(input word_t v);
    word_t x;
    x = v;
    x = x ^ ((x >> 29) & TEMPER_D);
    x = x ^ ((x << 17) & TEMPER_B);
    x = x ^ ((x << 37) & TEMPER_C);
    x = x ^ (x >> 43);
    temper = x;
  endfunction

endpackage
`default_nettype wire

@@ design/mt64_ram.sv @@
// mt64_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module mt64_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 312,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ design/mt64_mul.sv @@
// mt64_mul: 64x64 multiplier keeping the low 64 bits, built from one 32x32
// multiplier over three partial products. Depends on mt64_pkg.
`default_nettype none
module mt64_mul (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire mt64_pkg::word_t a,
  input  wire mt64_pkg::word_t b,
  output logic                 done,
  output mt64_pkg::word_t      prod
);

  mt64_pkg::word_t a_r, b_r, pp_r, acc_r, acc_nxt, pp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [31:0] opa, opb;

  // operand halves for the current partial product
  always_comb begin
    case (cnt_r)
      2'd0:    begin opa = a_r[31:0];  opb = b_r[31:0];  end
      2'd1:    begin opa = a_r[63:32]; opb = b_r[31:0];  end
      default: begin opa = a_r[31:0];  opb = b_r[63:32]; end
    endcase
  end

  // step sequence: each product is registered, then accumulated in the next cycle
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    acc_nxt  = acc_r;
    pp_nxt   = pp_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 2'd0;
    end else if (busy_r) begin
      pp_nxt  = 64'(opa * opb);
      cnt_nxt = cnt_r + 2'd1;
      case (cnt_r)
        2'd0:    acc_nxt = 64'd0;
        2'd1:    acc_nxt = pp_r;
        default: acc_nxt = acc_r + {pp_r[31:0], 32'd0};
      endcase
      if (cnt_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    acc_r <= acc_nxt;
    pp_r  <= pp_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

@@ design/mersenne_twister_64.sv @@
// mersenne_twister_64: top level of the 64-bit Mersenne Twister generator.
// Depends on mt64_pkg, mt64_ram and mt64_mul.
//
//  channel  | ports                                      | handshake
//  ---------+--------------------------------------------+-----------------
//  input    | in_kind, in_key_word, in_last_key          | in_valid/in_stall
//  result   | out_random_word                            | out_valid/out_stall
//  config   | cfg_seed_value                             | cfg_valid/cfg_ready
//
// A draw from a ready store is one state memory read, then tempering.
// A twist walks the store word by word: three reads, then a write of each word.
// Linear seeding writes one word per multiplier pass.
// Array seeding adds 623 steps after the linear pass.
// Reset is synchronous; the first draw seeds with 5489 and twists. The input stalls
// while an operation runs or while an unread result is held back by out_stall.
`default_nettype none
module mersenne_twister_64 (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [1:0]      in_kind,
  input  wire logic [63:0]     in_key_word,
  input  wire logic            in_last_key,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [63:0]          out_random_word,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [63:0]     cfg_seed_value
);

  localparam logic [mt64_pkg::IDX_W-1:0] IDX_END =
    mt64_pkg::IDX_W'(mt64_pkg::STATE_DEPTH);
  localparam logic [mt64_pkg::IDX_W-1:0] IDX_NEW =
    mt64_pkg::IDX_W'(mt64_pkg::STATE_DEPTH + 1);
  localparam logic [mt64_pkg::IDX_W-1:0] IDX_LAST =
    mt64_pkg::IDX_W'(mt64_pkg::STATE_DEPTH - 1);
  localparam logic [mt64_pkg::IDX_W-1:0] IDX_OFF =
    mt64_pkg::IDX_W'(mt64_pkg::TWIST_OFFSET);
  localparam logic [mt64_pkg::IDX_W-1:0] IDX_ONE = mt64_pkg::IDX_W'(1);

  mt64_pkg::state_t state_r, state_nxt;
  mt64_pkg::word_t seed_r, p_r, p_nxt, mti_r, mti_nxt, x_r, x_nxt, kj_r, kj_nxt;
  mt64_pkg::word_t out_word_r, out_word_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [mt64_pkg::IDX_W-1:0] idx_r, idx_nxt, i_r, i_nxt;
  logic [mt64_pkg::KEY_AW-1:0] j_r, j_nxt;
  logic [mt64_pkg::KEY_CW-1:0] kcnt_r, kcnt_nxt, len_r, len_nxt, len_c;
  logic [mt64_pkg::CNT_W-1:0] k_r, k_nxt;
  logic pend_draw_r, pend_draw_nxt, pend_arr_r, pend_arr_nxt;

  // memory and multiplier hookup
  logic st_we;
  logic [mt64_pkg::IDX_W-1:0] st_waddr, st_raddr, i_inc, i_wrap, i_off;
  mt64_pkg::word_t st_wdata, st_rdata, key_rdata, v;
  logic key_we;
  logic mul_start, mul_done;
  mt64_pkg::word_t mul_a, mul_b, mul_p;
  logic ls_go;
  mt64_pkg::word_t ls_val;
  logic in_acc;

  mt64_ram #(.WIDTH(64), .DEPTH(mt64_pkg::STATE_DEPTH), .AW(mt64_pkg::IDX_W)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  mt64_ram #(.WIDTH(64), .DEPTH(mt64_pkg::KEY_MAX_WORDS), .AW(mt64_pkg::KEY_AW)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (kcnt_r[mt64_pkg::KEY_AW-1:0]),
    .wdata (in_key_word),
    .raddr (j_r),
    .rdata (key_rdata)
  );

  mt64_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  assign in_stall  = (state_r != mt64_pkg::ST_IDLE) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_random_word = out_word_r;

  // neighbor indexes for the walk over the store
  assign i_inc  = (i_r == IDX_LAST) ? IDX_ONE : i_r + IDX_ONE;
  assign i_wrap = (i_r == IDX_LAST) ? '0 : i_r + IDX_ONE;
  assign i_off  = (i_r >= IDX_OFF) ? i_r - IDX_OFF : i_r + IDX_OFF;
  assign len_c  = (kcnt_r < mt64_pkg::KEY_CW'(mt64_pkg::KEY_MAX_WORDS)) ?
                  kcnt_r + mt64_pkg::KEY_CW'(1) : kcnt_r;

  // sequencer: next state, memory accesses and multiplier launches
  always_comb begin
    state_nxt     = state_r;
    p_nxt         = p_r;
    mti_nxt       = mti_r;
    x_nxt         = x_r;
    kj_nxt        = kj_r;
    idx_nxt       = idx_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    kcnt_nxt      = kcnt_r;
    len_nxt       = len_r;
    pend_draw_nxt = pend_draw_r;
    pend_arr_nxt  = pend_arr_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    st_we         = 1'b0;
    st_waddr      = i_r;
    st_wdata      = '0;
    st_raddr      = i_r;
    key_we        = 1'b0;
    mul_start     = 1'b0;
    mul_a         = mt64_pkg::mix62(p_r);
    mul_b         = mt64_pkg::INIT_MULT;
    ls_go         = 1'b0;
    ls_val        = seed_r;
    v             = '0;
    case (state_r)
      mt64_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_kind)
            mt64_pkg::KIND_DRAW: begin
              pend_draw_nxt = 1'b1;
              if (idx_r == IDX_NEW) begin
                ls_go  = 1'b1;
                ls_val = mt64_pkg::DEFAULT_SEED;
              end else if (idx_r == IDX_END) begin
                i_nxt     = '0;
                state_nxt = mt64_pkg::ST_TW_A;
              end else begin
                st_raddr  = idx_r;
                state_nxt = mt64_pkg::ST_DRAW_B;
              end
            end
            mt64_pkg::KIND_RESEED: begin
              ls_go = 1'b1;
            end
            mt64_pkg::KIND_KEY: begin
              if (kcnt_r < mt64_pkg::KEY_CW'(mt64_pkg::KEY_MAX_WORDS)) begin
                key_we   = 1'b1;
                kcnt_nxt = kcnt_r + mt64_pkg::KEY_CW'(1);
              end
              if (in_last_key) begin
                len_nxt      = len_c;
                pend_arr_nxt = 1'b1;
                ls_go        = 1'b1;
                ls_val       = mt64_pkg::ARRAY_SEED;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // linear seeding, one word per multiplier pass
      mt64_pkg::ST_LS_MUL: begin
        if (mul_done) begin
          v        = mul_p + 64'(i_r);
          st_we    = 1'b1;
          st_wdata = v;
          p_nxt    = v;
          if (i_r == IDX_LAST) begin
            idx_nxt = IDX_END;
            if (pend_arr_r) begin
              p_nxt     = mt64_pkg::ARRAY_SEED;
              i_nxt     = IDX_ONE;
              j_nxt     = '0;
              k_nxt     = (mt64_pkg::CNT_W'(len_r) > mt64_pkg::CNT_W'(mt64_pkg::STATE_DEPTH)) ?
                          mt64_pkg::CNT_W'(len_r) : mt64_pkg::CNT_W'(mt64_pkg::STATE_DEPTH);
              state_nxt = mt64_pkg::ST_A1_RD;
            end else if (pend_draw_r) begin
              i_nxt     = '0;
              state_nxt = mt64_pkg::ST_TW_A;
            end else begin
              state_nxt = mt64_pkg::ST_IDLE;
            end
          end else begin
            i_nxt     = i_r + IDX_ONE;
            mul_start = 1'b1;
            mul_a     = mt64_pkg::mix62(v);
          end
        end
      end
      // twist: read word i, i+1, i+offset, then write word i
      mt64_pkg::ST_TW_A: begin
        st_raddr  = i_r;
        state_nxt = mt64_pkg::ST_TW_B;
      end
      mt64_pkg::ST_TW_B: begin
        mti_nxt   = st_rdata;
        st_raddr  = i_wrap;
        state_nxt = mt64_pkg::ST_TW_C;
      end
      mt64_pkg::ST_TW_C: begin
        x_nxt     = {mti_r[63:31], st_rdata[30:0]};
        st_raddr  = i_off;
        state_nxt = mt64_pkg::ST_TW_D;
      end
      mt64_pkg::ST_TW_D: begin
        st_we    = 1'b1;
        st_wdata = st_rdata ^ (x_r >> 1) ^ (x_r[0] ? mt64_pkg::TWIST_MATRIX : 64'd0);
        if (i_r == IDX_LAST) begin
          idx_nxt   = '0;
          state_nxt = mt64_pkg::ST_DRAW_A;
        end else begin
          i_nxt     = i_r + IDX_ONE;
          state_nxt = mt64_pkg::ST_TW_A;
        end
      end
      // draw: read the word at the read index, temper into the output register
      mt64_pkg::ST_DRAW_A: begin
        st_raddr  = idx_r;
        state_nxt = mt64_pkg::ST_DRAW_B;
      end
      mt64_pkg::ST_DRAW_B: begin
        out_word_nxt  = mt64_pkg::temper(st_rdata);
        out_valid_nxt = 1'b1;
        idx_nxt       = idx_r + IDX_ONE;
        pend_draw_nxt = 1'b0;
        state_nxt     = mt64_pkg::ST_IDLE;
      end
      // array seeding, key mixing pass
      mt64_pkg::ST_A1_RD: begin
        st_raddr  = i_r;
        mul_start = 1'b1;
        mul_b     = mt64_pkg::MIX_MULT_A;
        state_nxt = mt64_pkg::ST_A1_CAP;
      end
      mt64_pkg::ST_A1_CAP: begin
        mti_nxt   = st_rdata;
        kj_nxt    = key_rdata + 64'(j_r);
        state_nxt = mt64_pkg::ST_A1_MUL;
      end
      mt64_pkg::ST_A1_MUL: begin
        if (mul_done) begin
          v        = (mti_r ^ mul_p) + kj_r;
          st_we    = 1'b1;
          st_wdata = v;
          p_nxt    = v;
          i_nxt    = i_inc;
          j_nxt    = (mt64_pkg::KEY_CW'(j_r) + mt64_pkg::KEY_CW'(1) >= len_r) ?
                     '0 : j_r + mt64_pkg::KEY_AW'(1);
          if (k_r == mt64_pkg::CNT_W'(1)) begin
            k_nxt     = mt64_pkg::CNT_W'(mt64_pkg::STATE_DEPTH - 1);
            state_nxt = mt64_pkg::ST_A2_RD;
          end else begin
            k_nxt     = k_r - mt64_pkg::CNT_W'(1);
            state_nxt = mt64_pkg::ST_A1_RD;
          end
        end
      end
      // array seeding, final scramble pass
      mt64_pkg::ST_A2_RD: begin
        st_raddr  = i_r;
        mul_start = 1'b1;
        mul_b     = mt64_pkg::MIX_MULT_B;
        state_nxt = mt64_pkg::ST_A2_CAP;
      end
      mt64_pkg::ST_A2_CAP: begin
        mti_nxt   = st_rdata;
        state_nxt = mt64_pkg::ST_A2_MUL;
      end
      mt64_pkg::ST_A2_MUL: begin
        if (mul_done) begin
          v        = (mti_r ^ mul_p) - 64'(i_r);
          st_we    = 1'b1;
          st_wdata = v;
          p_nxt    = v;
          i_nxt    = i_inc;
          k_nxt    = k_r - mt64_pkg::CNT_W'(1);
          state_nxt = (k_r == mt64_pkg::CNT_W'(1)) ? mt64_pkg::ST_FIN : mt64_pkg::ST_A2_RD;
        end
      end
      mt64_pkg::ST_FIN: begin
        st_we        = 1'b1;
        st_waddr     = '0;
        st_wdata     = mt64_pkg::TOP_BIT;
        idx_nxt      = IDX_END;
        kcnt_nxt     = '0;
        pend_arr_nxt = 1'b0;
        state_nxt    = mt64_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = mt64_pkg::ST_IDLE;
      end
    endcase

    // start of linear seeding: word 0 written now, first multiply launched
    if (ls_go) begin
      st_we     = 1'b1;
      st_waddr  = '0;
      st_wdata  = ls_val;
      p_nxt     = ls_val;
      i_nxt     = IDX_ONE;
      mul_start = 1'b1;
      mul_a     = mt64_pkg::mix62(ls_val);
      mul_b     = mt64_pkg::INIT_MULT;
      state_nxt = mt64_pkg::ST_LS_MUL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mt64_pkg::ST_IDLE;
      seed_r      <= mt64_pkg::DEFAULT_SEED;
      idx_r       <= IDX_NEW;
      kcnt_r      <= '0;
      out_valid_r <= 1'b0;
      pend_draw_r <= 1'b0;
      pend_arr_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      kcnt_r      <= kcnt_nxt;
      out_valid_r <= out_valid_nxt;
      pend_draw_r <= pend_draw_nxt;
      pend_arr_r  <= pend_arr_nxt;
      if (cfg_valid && cfg_ready) begin
        seed_r <= cfg_seed_value;
      end
    end
    p_r        <= p_nxt;
    mti_r      <= mti_nxt;
    x_r        <= x_nxt;
    kj_r       <= kj_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    len_r      <= len_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule
`default_nettype wire

@@ design/mt64_checker.sv @@
// mt64_checker: port-level assertions for mersenne_twister_64, bound to the top.
// Depends on mt64_pkg and the mersenne_twister_64 port names.
`default_nettype none
module mt64_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  in_kind,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] out_random_word,
  input wire logic        cfg_ready
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_random_word))
    else $error("result changed while stalled");

  // only a draw transaction can raise a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind != mt64_pkg::KIND_DRAW |=> !$rose(out_valid))
    else $error("result without a draw");

  // a draw keeps the input stalled while it is served
  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind == mt64_pkg::KIND_DRAW |=> in_stall)
    else $error("input taken during a draw");

  // configuration is always writable
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");

endmodule

bind mersenne_twister_64 mt64_checker u_mt64_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_kind         (in_kind),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_random_word (out_random_word),
  .cfg_ready       (cfg_ready)
);
`default_nettype wire

@@ dv/tb.sv @@
// tb: self-checking testbench for mersenne_twister_64 (64-bit Mersenne Twister).
// Depends on mt64_pkg and the design; predicts every drawn word and compares it.
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam mt64_pkg::word_t UPPER_MASK = 64'hFFFFFFFF80000000;
  localparam mt64_pkg::word_t LOWER_MASK = 64'h000000007FFFFFFF;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 7000;  // longest operation: linear pass plus key mixing
  localparam int CYCLE_LIMIT   = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = mt64_pkg::KIND_DRAW;
  logic [63:0] in_key_word = '0;
  logic        in_last_key = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_random_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_seed_value = '0;

  mersenne_twister_64 dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_key_word(in_key_word), .in_last_key(in_last_key),
    .out_valid(out_valid), .out_stall(out_stall), .out_random_word(out_random_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_seed_value(cfg_seed_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Generator model state
  mt64_pkg::word_t gen_words[mt64_pkg::STATE_DEPTH];
  int unsigned     gen_index;
  mt64_pkg::word_t key_words[mt64_pkg::KEY_MAX_WORDS];
  int unsigned     key_held;
  mt64_pkg::word_t seed_reg;
  mt64_pkg::word_t expected_words[$];

  bit tx_idle;
  bit rx_idle;
  int hold_cnt;
  int rx_wait;
  bit failed;
  int cycles;

  // Linear seeding of the whole store
  function automatic void load_linear(mt64_pkg::word_t s);
    mt64_pkg::word_t p;
    gen_words[0] = s;
    for (int i = 1; i < mt64_pkg::STATE_DEPTH; i++) begin
      p = gen_words[i-1];
      gen_words[i] = mt64_pkg::INIT_MULT * (p ^ (p >> 62)) + mt64_pkg::word_t'(i);
    end
    gen_index = mt64_pkg::STATE_DEPTH;
  endfunction

  // Array seeding from the collected key words
  function automatic void load_key(int unsigned len);
    int unsigned i, j, k;
    mt64_pkg::word_t p;
    i = 1;
    j = 0;
    load_linear(mt64_pkg::ARRAY_SEED);
    if (len == 0) len = 1;
    k = (len > mt64_pkg::STATE_DEPTH) ? len : mt64_pkg::STATE_DEPTH;
    while (k > 0) begin
      p = gen_words[i-1];
      gen_words[i] = (gen_words[i] ^ ((p ^ (p >> 62)) * mt64_pkg::MIX_MULT_A))
                     + key_words[j] + mt64_pkg::word_t'(j);
      i++;
      j++;
      if (i >= mt64_pkg::STATE_DEPTH) begin
        gen_words[0] = gen_words[mt64_pkg::STATE_DEPTH-1];
        i = 1;
      end
      if (j >= len) j = 0;
      k--;
    end
    for (k = mt64_pkg::STATE_DEPTH - 1; k > 0; k--) begin
      p = gen_words[i-1];
      gen_words[i] = (gen_words[i] ^ ((p ^ (p >> 62)) * mt64_pkg::MIX_MULT_B))
                     - mt64_pkg::word_t'(i);
      i++;
      if (i >= mt64_pkg::STATE_DEPTH) begin
        gen_words[0] = gen_words[mt64_pkg::STATE_DEPTH-1];
        i = 1;
      end
    end
    gen_words[0] = mt64_pkg::TOP_BIT;
    gen_index = mt64_pkg::STATE_DEPTH;
  endfunction

  // In-place twist of the store
  function automatic void regenerate();
    mt64_pkg::word_t x, y;
    for (int i = 0; i < mt64_pkg::STATE_DEPTH; i++) begin
      x = (gen_words[i] & UPPER_MASK)
          | (gen_words[(i+1) % mt64_pkg::STATE_DEPTH] & LOWER_MASK);
      y = gen_words[(i + mt64_pkg::TWIST_OFFSET) % mt64_pkg::STATE_DEPTH] ^ (x >> 1);
      if (x[0]) y = y ^ mt64_pkg::TWIST_MATRIX;
      gen_words[i] = y;
    end
    gen_index = 0;
  endfunction

  function automatic mt64_pkg::word_t next_word();
    mt64_pkg::word_t x;
    if (gen_index >= mt64_pkg::STATE_DEPTH) begin
      if (gen_index == mt64_pkg::STATE_DEPTH + 1) load_linear(mt64_pkg::DEFAULT_SEED);
      regenerate();
    end
    x = gen_words[gen_index];
    gen_index++;
    x = x ^ ((x >> 29) & mt64_pkg::TEMPER_D);
    x = x ^ ((x << 17) & mt64_pkg::TEMPER_B);
    x = x ^ ((x << 37) & mt64_pkg::TEMPER_C);
    x = x ^ (x >> 43);
    return x;
  endfunction

  // Update the model for one accepted transaction
  function automatic void predict_item(logic [1:0] kind, mt64_pkg::word_t key, logic last);
    case (kind)
      mt64_pkg::KIND_DRAW: begin
        expected_words.push_back(next_word());
      end
      mt64_pkg::KIND_RESEED: begin
        load_linear(seed_reg);
      end
      mt64_pkg::KIND_KEY: begin
        if (key_held < mt64_pkg::KEY_MAX_WORDS) begin
          key_words[key_held] = key;
          key_held++;
        end
        if (last) begin
          load_key(key_held);
          key_held = 0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic mt64_pkg::word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // Send one transaction; valid stays up afterward unless the next one idles
  task automatic send_item(logic [1:0] kind, mt64_pkg::word_t key, logic last);
    int gap;
    gap = tx_idle ? int'($urandom_range(0, 19)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_key_word <= key;
    in_last_key <= last;
    do @(posedge clk); while (in_stall);
    predict_item(kind, key, last);
  endtask

  // Drop valid, wait for all results and for any long operation to finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(mt64_pkg::word_t v);
    wait_idle();
    cfg_valid      <= 1'b1;
    cfg_seed_value <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    seed_reg = v;
  endtask

  task automatic send_key(int n, bit mixed);
    for (int i = 0; i < n; i++) begin
      if (mixed && $urandom_range(0, 3) == 0)
        send_item($urandom_range(0, 1) ? mt64_pkg::KIND_DRAW : mt64_pkg::KIND_RESEED,
                  rand_word(), 1'b0);
      send_item(mt64_pkg::KIND_KEY, rand_word(), i == n - 1);
    end
  endtask

  // Result side stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_wait = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) rx_wait = rx_idle ? int'($urandom_range(0, 19)) : 0;
      else if (rx_wait > 0) rx_wait--;
      out_stall <= (hold_cnt > 0) || (rx_wait > 0);
    end
  end

  // Long receiver hold-off
  always @(posedge clk) begin
    if (hold_cnt > 0) hold_cnt--;
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, out_random_word);
        failed = 1'b1;
      end else begin
        if (out_random_word !== expected_words[0]) begin
          $display("%0t: random_word mismatch, expected %h, actual %h",
                   $time, expected_words[0], out_random_word);
          failed = 1'b1;
        end
        void'(expected_words.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** mersenne_twister_64: FAILED **");
      $finish;
    end
  end

  // Default seed on first draw, unused kind ignored, value extremes
  task automatic test_default_draws();
    send_item(KIND_UNUSED, '1, 1'b1);
    send_item(mt64_pkg::KIND_DRAW, '0, 1'b0);
    send_item(mt64_pkg::KIND_DRAW, '1, 1'b1);
    send_item(KIND_UNUSED, '0, 1'b0);
    send_item(mt64_pkg::KIND_DRAW, '0, 1'b0);
  endtask

  // Reseed from the register at its extremes
  task automatic test_reseed();
    send_item(mt64_pkg::KIND_RESEED, '0, 1'b0);
    send_item(mt64_pkg::KIND_DRAW, '0, 1'b0);
    write_seed('0);
    send_item(mt64_pkg::KIND_RESEED, '1, 1'b1);
    send_item(mt64_pkg::KIND_DRAW, '0, 1'b0);
    send_item(mt64_pkg::KIND_DRAW, '0, 1'b0);
    write_seed('1);
    send_item(mt64_pkg::KIND_RESEED, '0, 1'b0);
    send_item(mt64_pkg::KIND_DRAW, '0, 1'b0);
  endtask

  // Key seeding: single word, key extremes, draw and reseed during collection
  task automatic test_key_seeding();
    send_item(mt64_pkg::KIND_KEY, '1, 1'b1);
    send_item(mt64_pkg::KIND_DRAW, '0, 1'b0);
    send_item(mt64_pkg::KIND_KEY, '0, 1'b0);
    send_item(mt64_pkg::KIND_DRAW, '0, 1'b0);
    send_item(mt64_pkg::KIND_RESEED, '0, 1'b0);
    send_item(mt64_pkg::KIND_KEY, '1, 1'b0);
    send_item(KIND_UNUSED, '0, 1'b1);
    send_item(mt64_pkg::KIND_KEY, 64'h0123456789ABCDEF, 1'b1);
    send_item(mt64_pkg::KIND_DRAW, '0, 1'b0);
    send_item(mt64_pkg::KIND_DRAW, '0, 1'b0);
  endtask

  // Receiver holds off while the sender keeps offering draws
  task automatic test_backpressure();
    hold_cnt = 400;
    for (int i = 0; i < 30; i++) send_item(mt64_pkg::KIND_DRAW, rand_word(), 1'b0);
  endtask

  // Sender pauses until every result has arrived
  task automatic test_drain_pause();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    for (int i = 0; i < 10; i++) send_item(mt64_pkg::KIND_DRAW, rand_word(), 1'b0);
  endtask

  // Key overflow: more words than the key store holds, then a key that fills it exactly
  task automatic test_key_overflow();
    send_key(mt64_pkg::KEY_MAX_WORDS + 6, 1'b0);
    send_item(mt64_pkg::KIND_DRAW, '0, 1'b0);
    send_key(mt64_pkg::KEY_MAX_WORDS, 1'b0);
    send_item(mt64_pkg::KIND_DRAW, '0, 1'b0);
  endtask

  // Mostly draws with occasional reseeds, key sequences and noise
  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) begin
        tx_idle = $urandom_range(0, 2) != 0;
        rx_idle = $urandom_range(0, 2) != 0;
      end
      r = int'($urandom_range(0, 999));
      if (r < 10) send_item(mt64_pkg::KIND_RESEED, rand_word(), 1'($urandom_range(0, 1)));
      else if (r < 18) send_key(int'($urandom_range(1, 8)), 1'b1);
      else if (r < 30) send_item(KIND_UNUSED, rand_word(), 1'($urandom_range(0, 1)));
      else send_item(mt64_pkg::KIND_DRAW, rand_word(), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    seed_reg = mt64_pkg::DEFAULT_SEED;
    gen_index = mt64_pkg::STATE_DEPTH + 1;
    key_held = 0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_cnt = 0;
    failed = 1'b0;
    cycles = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_draws();
    test_reseed();
    test_key_seeding();
    test_backpressure();
    test_drain_pause();
    test_key_overflow();
    write_seed(rand_word());
    test_random(450);
    write_seed(rand_word());
    test_random(450);

    wait_idle();
    if (!failed) begin
      $display("** mersenne_twister_64: PASSED **");
    end else begin
      $display("** mersenne_twister_64: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
